FILE: rtl/core/stacked_bar_peak_hold_macros.svh
// Assertion helpers shared by the bar meter modules.
// Every property is clocked on clk and switched off while rst is high.
`ifndef STACKED_BAR_PEAK_HOLD_MACROS_SVH
`define STACKED_BAR_PEAK_HOLD_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define SBPH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the trigger
`define SBPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sbph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbph_pkg;

  // Geometry and timing constants
  localparam int SEGMENTS  = 5;
  localparam int FRAC_BITS = 8;
  localparam int SEG_W     = 3;
  localparam int LOAD_W    = 16;
  localparam int BW_W      = 11;
  localparam int PROD_W    = LOAD_W + BW_W;
  localparam int QUO_W     = 20;
  localparam int POS_W     = 24;
  localparam int FC_W      = 8;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int DIV_CNT_W = 4;

  localparam logic [FC_W-1:0]  HOLD_FRAMES  = 8'd45;
  localparam logic [FC_W-1:0]  RELEASE_END  = 8'd140;
  localparam logic [QUO_W-1:0] MAX_W_Q8     = 20'(4095 << FRAC_BITS);
  localparam logic [QUO_W-1:0] ONE_Q8       = 20'(1 << FRAC_BITS);
  localparam logic [POS_W-1:0] POS_MAX      = 24'h7FFFFF;
  localparam logic [POS_W-1:0] POS_MIN      = 24'h800000;
  localparam logic [SEG_W-1:0] MARKER_IDX   = 3'(SEGMENTS % 8);
  localparam logic [SEG_W-1:0] LAST_SEG     = 3'(SEGMENTS - 1);
  localparam logic [8:0]       MARK_EXTRA_H = 9'd2;

  // Register indices on the configuration port
  localparam logic [2:0] CFG_FULL_SCALE = 3'd0;
  localparam logic [2:0] CFG_BAR_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_THICKNESS  = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_X   = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_Y   = 3'd4;

  // Input word: one frame of segment loads
  typedef struct packed {
    logic [LOAD_W-1:0] load_0;
    logic [LOAD_W-1:0] load_1;
    logic [LOAD_W-1:0] load_2;
    logic [LOAD_W-1:0] load_3;
    logic [LOAD_W-1:0] load_4;
  } in_word_t;

  // Output word: one rectangle
  typedef struct packed {
    logic [SEG_W-1:0]        segment_index;
    logic signed [POS_W-1:0] rect_x_q8;
    logic signed [11:0]      rect_y;
    logic [QUO_W-1:0]        rect_width_q8;
    logic [8:0]              rect_height;
    logic                    last_rect;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_SEG,
    ST_PEAK,
    ST_MARK
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic mul;
    logic div_start;
    logic seg_emit;
    logic seg_skip;
    logic peak_upd;
    logic mark_emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_busy;
    logic seg_drawn;
    logic seg_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sbph_div.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stacked_bar_peak_hold_macros.svh"

// Restoring divider, two quotient bits per cycle.
// Computes (dividend << FRAC_BITS) / divisor, saturated to MAX_W_Q8.
module sbph_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [sbph_pkg::PROD_W-1:0]     dividend,
  input  wire logic [sbph_pkg::LOAD_W-1:0]     divisor,
  output logic                                 busy,
  output logic [sbph_pkg::QUO_W-1:0]           quotient
);

  logic [sbph_pkg::LOAD_W-1:0]    dv;
  logic [sbph_pkg::LOAD_W-1:0]    rem;
  logic [sbph_pkg::LOAD_W-1:0]    rem_next;
  logic [sbph_pkg::QUO_W-1:0]     lo;
  logic [sbph_pkg::QUO_W-1:0]     lo_next;
  logic [sbph_pkg::QUO_W-1:0]     quo;
  logic [sbph_pkg::QUO_W-1:0]     quo_next;
  logic [sbph_pkg::DIV_CNT_W-1:0] cnt;
  logic                           ovf;
  logic [sbph_pkg::LOAD_W:0]      trial;

  // Two shift-and-subtract steps
  always_comb begin
    rem_next = rem;
    lo_next  = lo;
    quo_next = quo;
    trial    = '0;
    for (int k = 0; k < 2; k++) begin
      trial   = {rem_next, lo_next[sbph_pkg::QUO_W-1]};
      lo_next = {lo_next[sbph_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        rem_next = sbph_pkg::LOAD_W'(trial - {1'b0, dv});
        quo_next = {quo_next[sbph_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_next = trial[sbph_pkg::LOAD_W-1:0];
        quo_next = {quo_next[sbph_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  // Control: busy flag and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= sbph_pkg::DIV_CNT_W'(sbph_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: the high dividend bits seed the remainder; quotient above
  // QUO_W bits is caught by the overflow compare
  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= divisor;
      ovf <= {1'b0, dividend} >= {divisor, 12'b0};
      rem <= sbph_pkg::LOAD_W'(dividend[sbph_pkg::PROD_W-1:12]);
      lo  <= {dividend[11:0], {sbph_pkg::FRAC_BITS{1'b0}}};
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      lo  <= lo_next;
      quo <= quo_next;
    end
  end

  assign quotient = (ovf || (quo > sbph_pkg::MAX_W_Q8)) ? sbph_pkg::MAX_W_Q8 : quo;

  `SBPH_ASSERT_SAME(a_no_restart, start, !busy, "divider restarted while busy")
  `SBPH_ASSERT_NEXT(a_start_busy, start, busy, "divider did not go busy after start")

endmodule

`default_nettype wire

FILE: rtl/core/sbph_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stacked_bar_peak_hold_macros.svh"

// Frame sequencer: per segment multiply, divide, emit or skip; then the
// peak update and the marker.
module sbph_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sbph_pkg::dp_stat_t   stat,
  output sbph_pkg::ctrl_cmd_t       cmd
);

  sbph_pkg::ctrl_state_t state;
  sbph_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbph_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sbph_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = sbph_pkg::ST_MUL;
        end
      end
      sbph_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sbph_pkg::ST_DIV_INIT;
      end
      sbph_pkg::ST_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_next    = sbph_pkg::ST_DIV;
      end
      sbph_pkg::ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = sbph_pkg::ST_SEG;
        end
      end
      sbph_pkg::ST_SEG: begin
        if (!stat.seg_drawn) begin
          cmd.seg_skip = 1'b1;
          state_next   = stat.seg_last ? sbph_pkg::ST_PEAK : sbph_pkg::ST_MUL;
        end else if (stat.out_free) begin
          cmd.seg_emit = 1'b1;
          state_next   = stat.seg_last ? sbph_pkg::ST_PEAK : sbph_pkg::ST_MUL;
        end
      end
      sbph_pkg::ST_PEAK: begin
        cmd.peak_upd = 1'b1;
        state_next   = sbph_pkg::ST_MARK;
      end
      sbph_pkg::ST_MARK: begin
        if (stat.out_free) begin
          cmd.mark_emit = 1'b1;
          state_next    = sbph_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbph_pkg::ST_IDLE;
      end
    endcase
  end

  `SBPH_ASSERT_SAME(a_emit_free, cmd.seg_emit || cmd.mark_emit, stat.out_free,
                    "word loaded into a full output register")
  `SBPH_ASSERT_NEXT(a_peak_then_mark, cmd.peak_upd, state == sbph_pkg::ST_MARK,
                    "marker did not follow the peak update")

endmodule

`default_nettype wire

FILE: rtl/core/sbph_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stacked_bar_peak_hold_macros.svh"

// Configuration registers, load store, multiplier, divider, running end,
// peak-hold state and the output register.
module sbph_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire sbph_pkg::in_word_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sbph_pkg::out_word_t        out_data,
  input  wire sbph_pkg::ctrl_cmd_t   cmd,
  output sbph_pkg::dp_stat_t         stat
);

  logic [15:0]                     full_scale;
  logic [sbph_pkg::BW_W-1:0]       bar_width_px;
  logic [7:0]                      bar_thickness;
  logic [10:0]                     origin_x;
  logic [10:0]                     origin_y;

  logic [sbph_pkg::LOAD_W-1:0]     loads [sbph_pkg::SEGMENTS];
  logic [sbph_pkg::SEG_W-1:0]      seg;
  logic [sbph_pkg::PROD_W-1:0]     prod;
  logic [sbph_pkg::LOAD_W-1:0]     fs;
  logic                            div_busy;
  logic [sbph_pkg::QUO_W-1:0]      width_q8;
  logic [sbph_pkg::POS_W-1:0]      start;
  logic [sbph_pkg::POS_W:0]        end_sum;
  logic [sbph_pkg::POS_W-1:0]      end_next;
  logic [sbph_pkg::POS_W-1:0]      peak;
  logic [sbph_pkg::POS_W-1:0]      peak_next;
  logic [sbph_pkg::FC_W-1:0]       fc;
  logic [sbph_pkg::FC_W-1:0]       fc_next;
  logic                            new_max;
  logic [sbph_pkg::FC_W-1:0]       fc_base;
  logic [sbph_pkg::POS_W-1:0]      pk_base;
  logic [sbph_pkg::POS_W:0]        pk_dec;
  logic [11:0]                     y_bar;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale    <= 16'd65535;
      bar_width_px  <= 11'd256;
      bar_thickness <= 8'd2;
      origin_x      <= 11'd0;
      origin_y      <= 11'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbph_pkg::CFG_FULL_SCALE: full_scale    <= cfg_data;
        sbph_pkg::CFG_BAR_WIDTH:  bar_width_px  <= cfg_data[10:0];
        sbph_pkg::CFG_THICKNESS:  bar_thickness <= cfg_data[7:0];
        sbph_pkg::CFG_ORIGIN_X:   origin_x      <= cfg_data[10:0];
        sbph_pkg::CFG_ORIGIN_Y:   origin_y      <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Frame capture and segment counter
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      loads[0] <= in_data.load_0;
      loads[1] <= in_data.load_1;
      loads[2] <= in_data.load_2;
      loads[3] <= in_data.load_3;
      loads[4] <= in_data.load_4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= '0;
    end else if (cmd.load_item) begin
      seg <= '0;
    end else if (cmd.seg_emit || cmd.seg_skip) begin
      seg <= seg + 1'b1;
    end
  end

  // Load times bar width
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= loads[seg] * bar_width_px;
    end
  end

  // Zero full scale counts as one
  assign fs = (full_scale == '0) ? 16'd1 : full_scale;

  sbph_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (fs),
    .busy     (div_busy),
    .quotient (width_q8)
  );

  // Running end position, saturating
  assign end_sum  = {1'b0, start} + {{(sbph_pkg::POS_W + 1 - sbph_pkg::QUO_W){1'b0}}, width_q8};
  assign end_next = (end_sum > {1'b0, sbph_pkg::POS_MAX}) ? sbph_pkg::POS_MAX
                                                          : end_sum[sbph_pkg::POS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      start <= {{(sbph_pkg::POS_W - 11 - sbph_pkg::FRAC_BITS){1'b0}}, origin_x,
                {sbph_pkg::FRAC_BITS{1'b0}}};
    end else if (cmd.seg_emit) begin
      start <= end_next;
    end
  end

  // Peak hold, release and rest
  always_comb begin
    new_max   = $signed(start) > $signed(peak);
    fc_base   = new_max ? '0 : fc;
    pk_base   = new_max ? start : peak;
    pk_dec    = {pk_base[sbph_pkg::POS_W-1], pk_base}
              - {{(sbph_pkg::POS_W + 1 - sbph_pkg::QUO_W){1'b0}}, sbph_pkg::ONE_Q8};
    peak_next = pk_base;
    fc_next   = fc_base;
    priority if (fc_base < sbph_pkg::HOLD_FRAMES) begin
      fc_next = fc_base + 1'b1;
    end else if (fc_base < sbph_pkg::RELEASE_END) begin
      fc_next = fc_base + 1'b1;
      if (pk_dec[sbph_pkg::POS_W] != pk_dec[sbph_pkg::POS_W-1]) begin
        peak_next = sbph_pkg::POS_MIN;
      end else begin
        peak_next = pk_dec[sbph_pkg::POS_W-1:0];
      end
    end else begin
      peak_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
      fc   <= '0;
    end else if (cmd.peak_upd) begin
      peak <= peak_next;
      fc   <= fc_next;
    end
  end

  // Output register
  assign y_bar = {1'b0, origin_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.seg_emit || cmd.mark_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_emit) begin
      out_data.segment_index <= seg;
      out_data.rect_x_q8     <= $signed(start);
      out_data.rect_y        <= $signed(y_bar);
      out_data.rect_width_q8 <= width_q8;
      out_data.rect_height   <= {1'b0, bar_thickness};
      out_data.last_rect     <= 1'b0;
    end else if (cmd.mark_emit) begin
      out_data.segment_index <= sbph_pkg::MARKER_IDX;
      out_data.rect_x_q8     <= $signed(peak);
      out_data.rect_y        <= $signed(y_bar - 12'd1);
      out_data.rect_width_q8 <= sbph_pkg::ONE_Q8;
      out_data.rect_height   <= {1'b0, bar_thickness} + sbph_pkg::MARK_EXTRA_H;
      out_data.last_rect     <= 1'b1;
    end
  end

  // Status back to the controller
  assign stat.div_busy  = div_busy;
  assign stat.seg_drawn = width_q8 >= sbph_pkg::ONE_Q8;
  assign stat.seg_last  = seg == sbph_pkg::LAST_SEG;
  assign stat.out_free  = !out_valid || out_ready;

  `SBPH_ASSERT_NEXT(a_mark_last, cmd.mark_emit, out_valid && out_data.last_rect,
                    "marker word not flagged as last")
  `SBPH_ASSERT_NEXT(a_seg_not_last, cmd.seg_emit, out_valid && !out_data.last_rect,
                    "segment word flagged as last")

endmodule

`default_nettype wire

FILE: rtl/core/stacked_bar_peak_hold.sv
// Per segment: multiply, load of the shared serial divider, 10 divider steps at
// two quotient bits each, a done check, then emit or skip; after the last segment
// the peak update and the marker word. Each emit waits while the output stalls.
// The next frame word is taken only after the marker word has been loaded.
// Reset (rst, synchronous): configuration registers back to defaults, peak and hold count to 0.
`timescale 1ns / 1ps
`default_nettype none

module stacked_bar_peak_hold (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sbph_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sbph_pkg::out_word_t      out_data
);

  sbph_pkg::ctrl_cmd_t cmd;
  sbph_pkg::dp_stat_t  stat;

  sbph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbph_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

FILE: sim/stacked_bar_peak_hold_tb.sv
`timescale 1ns / 1ps

module stacked_bar_peak_hold_tb;
  import sbph_pkg::*;

  localparam int          STALL_MAX     = 18;
  localparam int          HOLD_OFF_LEN  = 1000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int          SCRIPT_LEN    = 25;
  localparam logic [2:0]  CFG_SPARE_LO  = 3'd5;
  localparam logic [2:0]  CFG_SPARE_HI  = 3'd7;
  localparam logic [2:0]  MARK_IDX      = 3'(SEGMENTS % 8);
  localparam longint      X_MAX         = 64'sd8388607;
  localparam longint      X_MIN         = -64'sd8388608;
  localparam longint unsigned W_MAX     = 64'd4095 << FRAC_BITS;
  localparam longint unsigned ONE_PX    = 64'd1 << FRAC_BITS;

  typedef enum {SHAPE_MIXED, SHAPE_DECAY} frame_shape_t;

  // One step of the directed script: a register write or a frame word
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [15:0] val;
    in_word_t    loads;
    logic        typed;
    out_word_t   mark;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;

  // Register mirror, reset values
  logic [15:0] fs_reg    = 16'hFFFF;
  logic [10:0] bw_reg    = 11'd256;
  logic [7:0]  thick_reg = 8'd2;
  logic [10:0] ox_reg    = 11'd0;
  logic [10:0] oy_reg    = 11'd0;

  // Peak tracker state
  longint peak_q8    = 0;
  int     hold_count = 0;

  out_word_t pending_rects [$];
  out_word_t frame_rects [$];
  out_word_t want;

  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_off_req = 1'b0;
  int mismatches   = 0;

  stacked_bar_peak_hold dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Rectangles of one frame into frame_rects; advances the peak tracker
  function automatic void draw_frame(input in_word_t w);
    logic [15:0]     loads [SEGMENTS];
    longint unsigned span;
    longint unsigned wq;
    longint          run_x;
    out_word_t       r;
    int              i;
    loads = '{w.load_0, w.load_1, w.load_2, w.load_3, w.load_4};
    frame_rects.delete();
    span  = (fs_reg == 16'd0) ? 64'd1 : 64'(fs_reg);
    run_x = longint'(64'(ox_reg) << FRAC_BITS);
    for (i = 0; i < SEGMENTS; i++) begin
      wq = ((64'(loads[i]) * 64'(bw_reg)) << FRAC_BITS) / span;
      if (wq > W_MAX) wq = W_MAX;
      // sub-pixel segments are dropped
      if (wq >= ONE_PX) begin
        r.segment_index = 3'(i);
        r.rect_x_q8     = run_x[23:0];
        r.rect_y        = {1'b0, oy_reg};
        r.rect_width_q8 = wq[19:0];
        r.rect_height   = {1'b0, thick_reg};
        r.last_rect     = 1'b0;
        frame_rects.push_back(r);
        run_x += longint'(wq);
        if (run_x > X_MAX) run_x = X_MAX;
      end
    end
    // jump on a new maximum, hold, then creep back, then rest at zero
    if (run_x > peak_q8) begin
      peak_q8    = run_x;
      hold_count = 0;
    end
    if (hold_count < HOLD_FRAMES) begin
      hold_count++;
    end else if (hold_count < RELEASE_END) begin
      peak_q8 -= longint'(ONE_PX);
      if (peak_q8 < X_MIN) peak_q8 = X_MIN;
      hold_count++;
    end else begin
      peak_q8 = 0;
    end
    r.segment_index = MARK_IDX;
    r.rect_x_q8     = peak_q8[23:0];
    r.rect_y        = {1'b0, oy_reg} - 12'd1;
    r.rect_width_q8 = 20'(ONE_PX);
    r.rect_height   = {1'b0, thick_reg} + 9'd2;
    r.last_rect     = 1'b1;
    frame_rects.push_back(r);
  endfunction

  function automatic script_row_t cfg_row(input logic [2:0] idx, input logic [15:0] val);
    script_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic script_row_t load_row(input in_word_t w);
    script_row_t row;
    row       = '0;
    row.loads = w;
    return row;
  endfunction

  // Frame in which nothing is drawn and the peak is still at zero
  function automatic script_row_t mark_row(input in_word_t w, input logic [11:0] y,
                                           input logic [8:0] h);
    script_row_t row;
    row                    = '0;
    row.loads              = w;
    row.typed              = 1'b1;
    row.mark.segment_index = MARK_IDX;
    row.mark.rect_x_q8     = 24'sd0;
    row.mark.rect_y        = y;
    row.mark.rect_width_q8 = 20'd256;
    row.mark.rect_height   = h;
    row.mark.last_rect     = 1'b1;
    return row;
  endfunction

  script_row_t script [SCRIPT_LEN] = '{
    mark_row(80'h0, 12'hFFF, 9'd4),
    mark_row({5{16'h00FF}}, 12'hFFF, 9'd4),     // just under one pixel each
    cfg_row(CFG_ORIGIN_Y, 16'd2047),
    cfg_row(CFG_THICKNESS, 16'd255),
    mark_row(80'h0, 12'd2046, 9'd257),
    cfg_row(CFG_THICKNESS, 16'd1),
    cfg_row(CFG_ORIGIN_Y, 16'd0),
    mark_row({5{16'h00FF}}, 12'hFFF, 9'd3),
    load_row({5{16'h0100}}),                     // exactly one pixel each
    load_row({5{16'hFFFF}}),
    load_row({16'hFFFF, 64'h0}),
    load_row({64'h0, 16'hFFFF}),
    load_row({16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h0001}),
    load_row({16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'h0100}),
    cfg_row(CFG_SPARE_HI, 16'hFFFF),             // unused indexes, no effect
    cfg_row(CFG_SPARE_LO, 16'h0000),
    load_row({16'h1234, 16'h0FED, 16'hC001, 16'h0042, 16'h7FFE}),
    cfg_row(CFG_FULL_SCALE, 16'd0),              // treated as one
    load_row({16'd1, 16'd2, 16'd0, 16'd3, 16'd0}),
    cfg_row(CFG_BAR_WIDTH, 16'd2047),
    load_row({5{16'hFFFF}}),                     // every segment saturates
    cfg_row(CFG_ORIGIN_X, 16'd2047),
    load_row({16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF}),
    cfg_row(CFG_BAR_WIDTH, 16'd0),               // nothing can be drawn
    load_row({5{16'hFFFF}})
  };

  function automatic logic [15:0] pick_load();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      4:       return 16'($urandom_range(0, 511));
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic in_word_t mixed_frame();
    return {pick_load(), pick_load(), pick_load(), pick_load(), pick_load()};
  endfunction

  // Mostly empty frames, now and then one faint segment
  function automatic in_word_t quiet_frame();
    in_word_t w;
    w = '0;
    if ($urandom_range(0, 5) == 0)
      w = in_word_t'(80'($urandom_range(0, 300)) << (16 * $urandom_range(0, 4)));
    return w;
  endfunction

  function automatic void check_field(input string field, input logic [23:0] want_v,
                                      input logic [23:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_FULL_SCALE: fs_reg    = val;
      CFG_BAR_WIDTH:  bw_reg    = val[10:0];
      CFG_THICKNESS:  thick_reg = val[7:0];
      CFG_ORIGIN_X:   ox_reg    = val[10:0];
      CFG_ORIGIN_Y:   oy_reg    = val[10:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] fs, input logic [15:0] bw,
                            input logic [15:0] th, input logic [15:0] ox,
                            input logic [15:0] oy);
    quiesce();
    write_reg(CFG_FULL_SCALE, fs);
    write_reg(CFG_BAR_WIDTH, bw);
    write_reg(CFG_THICKNESS, th);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
  endtask

  // Offer one frame word; queue its rectangles once taken
  task automatic push_frame(input in_word_t w, input bit typed, input out_word_t mark);
    int gap;
    gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    draw_frame(w);
    if (typed) begin
      pending_rects.push_back(mark);
    end else begin
      foreach (frame_rects[i]) pending_rects.push_back(frame_rects[i]);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_frames(input int n, input frame_shape_t shape, input in_word_t first);
    in_word_t w;
    int       j;
    for (j = 0; j < n; j++) begin
      if (shape == SHAPE_DECAY) w = (j == 0) ? first : quiet_frame();
      else w = mixed_frame();
      push_frame(w, 1'b0, '0);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    script_row_t row;
    int          k;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FULL_SCALE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed script
    for (k = 0; k < SCRIPT_LEN; k++) begin
      row = script[k];
      if (row.is_cfg) begin
        quiesce();
        write_reg(row.idx, row.val);
      end else begin
        push_frame(row.loads, row.typed, row.mark);
      end
    end

    // top of every register range but full scale, which is set to one
    set_config(16'd1, 16'd2047, 16'd255, 16'd2047, 16'd2047);
    run_frames(30, SHAPE_MIXED, '0);

    // back-to-back input against a long output hold-off
    set_config(16'hFFFF, 16'($urandom_range(1, 2047)), 16'($urandom_range(1, 255)),
               16'($urandom_range(0, 255)), 16'($urandom_range(0, 2047)));
    send_idle    = 1'b0;
    hold_off_req = 1'b1;
    run_frames(30, SHAPE_MIXED, '0);

    // tall peak, then quiet frames: hold, release and rest
    send_idle = 1'b1;
    set_config(16'hFFFF, 16'($urandom_range(64, 400)), 16'($urandom_range(1, 255)),
               16'd0, 16'($urandom_range(0, 2047)));
    run_frames(150, SHAPE_DECAY, {5{16'hFFFF}});

    // short peak that creeps back below zero
    recv_idle = 1'b0;
    set_config(16'hFFFF, 16'd256, 16'd1, 16'd0, 16'd0);
    run_frames(70, SHAPE_DECAY, {16'd5000, 64'h0});

    // random settings, no idling on either side
    send_idle = 1'b0;
    set_config(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
               16'($urandom_range(0, 2047)), 16'($urandom_range(0, 255)),
               16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)));
    run_frames(30, SHAPE_MIXED, '0);

    // drain, then look for stray words
    in_valid <= 1'b0;
    k = 0;
    while (pending_rects.size() != 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    repeat (100) @(posedge clk);
    if (pending_rects.size() != 0) begin
      $display("%0t: %0d rectangles never arrived", $time, pending_rects.size());
      mismatches += pending_rects.size();
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off on request
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        stall        = HOLD_OFF_LEN;
        hold_off_req = 1'b0;
      end else begin
        stall = recv_idle ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each output word with the oldest expected rectangle
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_rects.size() == 0) begin
        $display("%0t: rectangle expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_rects.pop_front();
        check_field("segment_index", want.segment_index, out_data.segment_index);
        check_field("rect_x_q8", want.rect_x_q8, out_data.rect_x_q8);
        check_field("rect_y", want.rect_y, out_data.rect_y);
        check_field("rect_width_q8", want.rect_width_q8, out_data.rect_width_q8);
        check_field("rect_height", want.rect_height, out_data.rect_height);
        check_field("last_rect", want.last_rect, out_data.last_rect);
      end
    end
  end

  // Hang guard
  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
